// File: rtl/look_direction_to_quaternion_top_macros.svh
// assertion macros for the look direction to quaternion block
`ifndef LOOK_DIRECTION_TO_QUATERNION_TOP_MACROS_SVH
`define LOOK_DIRECTION_TO_QUATERNION_TOP_MACROS_SVH
`ifndef SYNTH
`define LDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldq assertion failed");
`define LDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldq assertion failed");
`else
`define LDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ldq_pkg.sv
// shared types, constants and helpers of the look direction to quaternion block
package ldq_pkg;

    localparam int FRAC_BITS = 14;
    localparam logic signed [15:0] ONE_Q = 16'sd16384;

    typedef enum logic [1:0] {
        CASE_TRACE,
        CASE_X,
        CASE_Y,
        CASE_Z
    } t_case;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] res;
        if (v > 32'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/look_direction_to_quaternion_top.sv
// look direction to orientation quaternion, fully pipelined
//
// channel | dir | handshake           | beat
// --------+-----+---------------------+----------------------------------------
// input   | in  | i_valid / o_stall   | i_fwd_x/y/z, i_up_x/y/z
// output  | out | o_valid / i_stall   | o_quat_w/x/y/z, o_degenerate
//
// one beat enters per cycle while o_stall is low
// latency is set by the three root units (two 64-bit, one 32-bit) and the dividers, one bit a stage
// i_rst_n is synchronous and clears only the valid bits
// a held output stalls the pipe only when the stage behind it is also full,
// so bubbles close up while a result waits
`include "look_direction_to_quaternion_top_macros.svh"

module look_direction_to_quaternion_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_fwd_x,
    input  logic signed [15:0] i_fwd_y,
    input  logic signed [15:0] i_fwd_z,
    input  logic signed [15:0] i_up_x,
    input  logic signed [15:0] i_up_y,
    input  logic signed [15:0] i_up_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    output logic               o_degenerate
);
    import ldq_pkg::*;

    logic w_en;
    logic w_oload;

    // first cross product
    logic signed [31:0] w_pa [3];
    logic signed [31:0] w_pb [3];
    logic signed [32:0] w_c [3];
    logic               r_s1_vld;
    logic signed [32:0] r_s1_c [3];
    logic [47:0]        r_s1_f;

    logic               w_n1_vld;
    logic signed [15:0] w_r [3];
    logic               w_z1;
    logic [47:0]        w_n1_pay;

    // second cross product
    logic signed [15:0] w_f1 [3];
    logic signed [31:0] w_qa [3];
    logic signed [31:0] w_qb [3];
    logic               r_s2_vld;
    logic signed [32:0] r_s2_u [3];
    logic [96:0]        r_s2_pay;

    logic               w_n2_vld;
    logic signed [15:0] w_u [3];
    logic               w_z2;
    logic [96:0]        w_n2_pay;

    // matrix and case choice
    logic signed [17:0] w_m00, w_m10, w_m20, w_m01, w_m11, w_m21, w_m02, w_m12, w_m22;
    logic signed [18:0] w_tr;
    logic signed [18:0] w_rad;
    logic [16:0]        w_radc;
    logic signed [17:0] w_num [3];
    t_case              w_case;
    logic               r_s3_vld;
    logic [31:0]        r_s3_rad;
    logic signed [17:0] r_s3_num [3];
    t_case              r_s3_case;
    logic               r_s3_deg;

    logic               w_sq_vld;
    logic [16:0]        w_s;
    logic [56:0]        w_sq_pay;
    logic signed [17:0] w_dnum [3];

    logic               w_d2_vld;
    logic signed [30:0] w_q [3];
    logic [19:0]        w_d2_pay;

    // output stage
    logic [16:0]        w_qs;
    t_case              w_ocase;
    logic signed [15:0] w_sq0, w_sq1, w_sq2, w_sqs;
    logic signed [15:0] n_w, n_x, n_y, n_z;
    logic               r_o_vld;
    logic signed [15:0] r_o_w, r_o_x, r_o_y, r_o_z;
    logic               r_o_deg;

    assign w_oload = !r_o_vld || !i_stall;
    assign w_en    = !(r_o_vld && i_stall && w_d2_vld);
    assign o_stall = !w_en;

    always_comb begin
        w_pa[0] = i_fwd_y * i_up_z;
        w_pb[0] = i_fwd_z * i_up_y;
        w_pa[1] = i_fwd_z * i_up_x;
        w_pb[1] = i_fwd_x * i_up_z;
        w_pa[2] = i_fwd_x * i_up_y;
        w_pb[2] = i_fwd_y * i_up_x;
        for (int l = 0; l < 3; l++) begin
            w_c[l] = 33'(w_pa[l]) - 33'(w_pb[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= w_n1_vld;
            r_s3_vld <= w_n2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_c <= w_c;
            r_s1_f <= {i_fwd_z, i_fwd_y, i_fwd_x};
        end
    end

    ldq_norm #(
        .PW (48)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_vld),
        .i_vec   (r_s1_c),
        .i_pay   (r_s1_f),
        .o_valid (w_n1_vld),
        .o_unit  (w_r),
        .o_zero  (w_z1),
        .o_pay   (w_n1_pay)
    );

    always_comb begin
        w_f1[0] = w_n1_pay[15:0];
        w_f1[1] = w_n1_pay[31:16];
        w_f1[2] = w_n1_pay[47:32];
        w_qa[0] = w_r[1] * w_f1[2];
        w_qb[0] = w_r[2] * w_f1[1];
        w_qa[1] = w_r[2] * w_f1[0];
        w_qb[1] = w_r[0] * w_f1[2];
        w_qa[2] = w_r[0] * w_f1[1];
        w_qb[2] = w_r[1] * w_f1[0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s2_u[l] <= 33'(w_qa[l]) - 33'(w_qb[l]);
            end
            r_s2_pay <= {w_n1_pay, w_r[2], w_r[1], w_r[0], w_z1};
        end
    end

    ldq_norm #(
        .PW (97)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_vec   (r_s2_u),
        .i_pay   (r_s2_pay),
        .o_valid (w_n2_vld),
        .o_unit  (w_u),
        .o_zero  (w_z2),
        .o_pay   (w_n2_pay)
    );

    always_comb begin
        w_m00 = 18'(signed'(w_n2_pay[16:1]));
        w_m10 = 18'(signed'(w_n2_pay[32:17]));
        w_m20 = 18'(signed'(w_n2_pay[48:33]));
        w_m01 = 18'(w_u[0]);
        w_m11 = 18'(w_u[1]);
        w_m21 = 18'(w_u[2]);
        w_m02 = -18'(signed'(w_n2_pay[64:49]));
        w_m12 = -18'(signed'(w_n2_pay[80:65]));
        w_m22 = -18'(signed'(w_n2_pay[96:81]));
        w_tr  = 19'(w_m00) + 19'(w_m11) + 19'(w_m22);
        if (w_tr > 19'sd0) begin
            w_case   = CASE_TRACE;
            w_rad    = w_tr + 19'(ONE_Q);
            w_num[0] = w_m21 - w_m12;
            w_num[1] = w_m02 - w_m20;
            w_num[2] = w_m10 - w_m01;
        end else if (w_m00 > w_m11 && w_m00 > w_m22) begin
            w_case   = CASE_X;
            w_rad    = 19'(ONE_Q) + 19'(w_m00) - 19'(w_m11) - 19'(w_m22);
            w_num[0] = w_m01 + w_m10;
            w_num[1] = w_m02 + w_m20;
            w_num[2] = w_m21 - w_m12;
        end else if (w_m11 > w_m22) begin
            w_case   = CASE_Y;
            w_rad    = 19'(ONE_Q) + 19'(w_m11) - 19'(w_m00) - 19'(w_m22);
            w_num[0] = w_m01 + w_m10;
            w_num[1] = w_m12 + w_m21;
            w_num[2] = w_m02 - w_m20;
        end else begin
            w_case   = CASE_Z;
            w_rad    = 19'(ONE_Q) + 19'(w_m22) - 19'(w_m00) - 19'(w_m11);
            w_num[0] = w_m02 + w_m20;
            w_num[1] = w_m12 + w_m21;
            w_num[2] = w_m10 - w_m01;
        end
        w_radc = w_rad[18] ? 17'd0 : w_rad[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_rad  <= 32'({w_radc, {FRAC_BITS{1'b0}}});
            r_s3_num  <= w_num;
            r_s3_case <= w_case;
            r_s3_deg  <= w_n2_pay[0] || w_z2;
        end
    end

    ldq_sqrt #(
        .IW (32),
        .PW (57)
    ) u_sqrt_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_vld),
        .i_rad   (r_s3_rad),
        .i_pay   ({r_s3_num[2], r_s3_num[1], r_s3_num[0], r_s3_case, r_s3_deg}),
        .o_valid (w_sq_vld),
        .o_root  (w_s),
        .o_pay   (w_sq_pay)
    );

    assign w_dnum[0] = w_sq_pay[20:3];
    assign w_dnum[1] = w_sq_pay[38:21];
    assign w_dnum[2] = w_sq_pay[56:39];

    ldq_div #(
        .NW (18),
        .DW (18),
        .QW (30),
        .PW (20)
    ) u_div_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_vld),
        .i_num   (w_dnum),
        .i_den   ({w_s, 1'b0}),
        .i_pay   ({w_s, w_sq_pay[2:0]}),
        .o_valid (w_d2_vld),
        .o_quo   (w_q),
        .o_pay   (w_d2_pay)
    );

    always_comb begin
        w_qs    = 17'(({1'b0, w_d2_pay[19:3]} + 18'd1) >> 1);
        w_ocase = t_case'(w_d2_pay[2:1]);
        w_sq0   = sat16(32'(w_q[0]));
        w_sq1   = sat16(32'(w_q[1]));
        w_sq2   = sat16(32'(w_q[2]));
        w_sqs   = sat16(32'(w_qs));
        case (w_ocase)
            CASE_TRACE: begin
                n_w = w_sqs; n_x = w_sq0; n_y = w_sq1; n_z = w_sq2;
            end
            CASE_X: begin
                n_w = w_sq2; n_x = w_sqs; n_y = w_sq0; n_z = w_sq1;
            end
            CASE_Y: begin
                n_w = w_sq2; n_x = w_sq0; n_y = w_sqs; n_z = w_sq1;
            end
            CASE_Z: begin
                n_w = w_sq2; n_x = w_sq0; n_y = w_sq1; n_z = w_sqs;
            end
            default: begin
                n_w = w_sqs; n_x = w_sq0; n_y = w_sq1; n_z = w_sq2;
            end
        endcase
        if (w_d2_pay[0]) begin
            n_w = ONE_Q;
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_oload) begin
            r_o_vld <= w_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_o_w   <= n_w;
            r_o_x   <= n_x;
            r_o_y   <= n_y;
            r_o_z   <= n_z;
            r_o_deg <= w_d2_pay[0];
        end
    end

    assign o_valid      = r_o_vld;
    assign o_quat_w     = r_o_w;
    assign o_quat_x     = r_o_x;
    assign o_quat_y     = r_o_y;
    assign o_quat_z     = r_o_z;
    assign o_degenerate = r_o_deg;

    `LDQ_ASSERT_IMPL(a_deg_identity, i_clk, i_rst_n, o_valid && o_degenerate, o_quat_w == ONE_Q && o_quat_x == 16'sd0 && o_quat_y == 16'sd0 && o_quat_z == 16'sd0)
    `LDQ_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, r_o_vld && i_stall && w_d2_vld)
    `LDQ_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_s1_vld)

endmodule

// File: rtl/ldq_sqrt.sv
// pipelined rounded integer square root, one result bit per stage
module ldq_sqrt #(
    parameter int IW = 64,
    parameter int PW = 1,
    localparam int OW = IW / 2 + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [IW-1:0] i_rad,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [OW-1:0] o_root,
    output logic [PW-1:0] o_pay
);

    localparam int NS = IW / 2;
    localparam int RW = IW + 1;

    logic [IW-1:0] r_n   [0:NS-1];
    logic [RW-1:0] r_res [0:NS-1];
    logic          r_vld [0:NS-1];
    logic [PW-1:0] r_pay [0:NS-1];
    logic          r_o_vld;
    logic [OW-1:0] r_o_root;
    logic [PW-1:0] r_o_pay;

    for (genvar j = 0; j < NS; j++) begin : g_step
        localparam logic [RW-1:0] BITV = RW'(1) << (2 * (NS - 1 - j));
        logic [IW-1:0] w_n;
        logic [RW-1:0] w_res;
        logic          w_v;
        logic [PW-1:0] w_p;
        logic [RW-1:0] w_sum;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_n   = i_rad;
            assign w_res = '0;
            assign w_v   = i_valid;
            assign w_p   = i_pay;
        end else begin : g_next
            assign w_n   = r_n[j-1];
            assign w_res = r_res[j-1];
            assign w_v   = r_vld[j-1];
            assign w_p   = r_pay[j-1];
        end

        assign w_sum = w_res + BITV;
        assign w_ge  = {1'b0, w_n} >= w_sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[j]   <= w_ge ? w_n - w_sum[IW-1:0] : w_n;
                r_res[j] <= w_ge ? (w_res >> 1) + BITV : w_res >> 1;
                r_pay[j] <= w_p;
            end
        end
    end

    // round to nearest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_root <= r_res[NS-1][OW-1:0]
                + OW'({1'b0, r_n[NS-1]} > r_res[NS-1]);
            r_o_pay  <= r_pay[NS-1];
        end
    end

    assign o_valid = r_o_vld;
    assign o_root  = r_o_root;
    assign o_pay   = r_o_pay;

endmodule

// File: rtl/ldq_div.sv
// pipelined three lane rounded divider, num * 2^frac / den, one quotient bit per stage
module ldq_div #(
    parameter int NW = 32,
    parameter int DW = 33,
    parameter int QW = 15,
    parameter int PW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [NW-1:0] i_num [3],
    input  logic [DW-1:0]        i_den,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic signed [QW:0]   o_quo [3],
    output logic [PW-1:0]        o_pay
);
    import ldq_pkg::*;

    localparam int TW = NW + FRAC_BITS + 1;
    localparam int CW = (TW > DW + QW) ? TW : DW + QW;

    logic [CW-1:0]   r_rem [0:QW][3];
    logic [QW-1:0]   r_q   [0:QW][3];
    logic [2:0]      r_neg [0:QW];
    logic [DW-1:0]   r_den [0:QW];
    logic            r_dz  [0:QW];
    logic            r_vld [0:QW];
    logic [PW-1:0]   r_pay [0:QW];
    logic [NW-1:0]   w_mag [3];
    logic            r_o_vld;
    logic signed [QW:0] r_o_quo [3];
    logic [PW-1:0]   r_o_pay;

    // magnitude, scale and rounding offset
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = i_num[l][NW-1] ? NW'(-i_num[l]) : NW'(i_num[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= CW'({w_mag[l], {FRAC_BITS{1'b0}}}) + CW'(i_den >> 1);
                r_q[0][l]   <= '0;
                r_neg[0][l] <= i_num[l][NW-1];
            end
            r_den[0] <= i_den;
            r_dz[0]  <= (i_den == '0);
            r_pay[0] <= i_pay;
        end
    end

    for (genvar i = 1; i <= QW; i++) begin : g_step
        localparam int B = QW - i;
        logic [CW-1:0] w_sh;
        logic [2:0]    w_ge;

        always_comb begin
            w_sh = CW'(r_den[i-1]) << B;
            for (int l = 0; l < 3; l++) begin
                w_ge[l] = r_rem[i-1][l] >= w_sh;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[i][l] <= w_ge[l] ? r_rem[i-1][l] - w_sh : r_rem[i-1][l];
                    r_q[i][l]   <= r_q[i-1][l] | (w_ge[l] ? QW'(1) << B : QW'(0));
                end
                r_neg[i] <= r_neg[i-1];
                r_den[i] <= r_den[i-1];
                r_dz[i]  <= r_dz[i-1];
                r_pay[i] <= r_pay[i-1];
            end
        end
    end

    // sign and zero divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                if (r_dz[QW]) begin
                    r_o_quo[l] <= '0;
                end else if (r_neg[QW][l]) begin
                    r_o_quo[l] <= -$signed({1'b0, r_q[QW][l]});
                end else begin
                    r_o_quo[l] <= $signed({1'b0, r_q[QW][l]});
                end
            end
            r_o_pay <= r_pay[QW];
        end
    end

    assign o_valid = r_o_vld;
    assign o_quo   = r_o_quo;
    assign o_pay   = r_o_pay;

endmodule

// File: rtl/ldq_norm.sv
// pipelined vector normalization: prescale, squares, sum, root, three divisions
module ldq_norm #(
    parameter int PW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [32:0] i_vec [3],
    input  logic [PW-1:0]      i_pay,
    output logic               o_valid,
    output logic signed [15:0] o_unit [3],
    output logic               o_zero,
    output logic [PW-1:0]      o_pay
);
    import ldq_pkg::*;

    localparam int SPW = 96 + 1 + PW;

    logic [32:0]        w_mag [3];
    logic signed [32:0] w_adj [3];
    logic               w_shift;
    logic signed [31:0] w_vs [3];
    logic [31:0]        w_m [3];

    logic               r_a_vld;
    logic signed [31:0] r_a_vs [3];
    logic [PW-1:0]      r_a_pay;
    logic               r_b_vld;
    logic signed [31:0] r_b_vs [3];
    logic [63:0]        r_b_sq [3];
    logic [PW-1:0]      r_b_pay;
    logic               r_c_vld;
    logic signed [31:0] r_c_vs [3];
    logic [63:0]        r_c_len2;
    logic               r_c_zero;
    logic [PW-1:0]      r_c_pay;

    logic [SPW-1:0]     w_sp_in;
    logic [SPW-1:0]     w_sp_out;
    logic               w_sp_vld;
    logic [32:0]        w_len;
    logic signed [31:0] w_dnum [3];
    logic signed [15:0] w_quo [3];
    logic [PW:0]        w_dpay;

    // bring all components into the 32-bit signed range, truncating toward zero
    always_comb begin
        w_shift = 1'b0;
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = i_vec[l][32] ? 33'(-i_vec[l]) : 33'(i_vec[l]);
            if (w_mag[l][32:31] != 2'b00) begin
                w_shift = 1'b1;
            end
        end
        for (int l = 0; l < 3; l++) begin
            w_adj[l] = i_vec[l] + $signed({32'b0, i_vec[l][32] & i_vec[l][0]});
            w_adj[l] = w_adj[l] >>> 1;
            w_vs[l]  = w_shift ? w_adj[l][31:0] : i_vec[l][31:0];
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_m[l] = r_a_vs[l][31] ? 32'(-r_a_vs[l]) : 32'(r_a_vs[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_vs   <= w_vs;
            r_a_pay  <= i_pay;
            for (int l = 0; l < 3; l++) begin
                r_b_sq[l] <= {32'b0, w_m[l]} * {32'b0, w_m[l]};
            end
            r_b_vs   <= r_a_vs;
            r_b_pay  <= r_a_pay;
            r_c_len2 <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
            r_c_zero <= (r_b_sq[0] == '0) && (r_b_sq[1] == '0) && (r_b_sq[2] == '0);
            r_c_vs   <= r_b_vs;
            r_c_pay  <= r_b_pay;
        end
    end

    assign w_sp_in = {r_c_vs[2], r_c_vs[1], r_c_vs[0], r_c_zero, r_c_pay};

    ldq_sqrt #(
        .IW (64),
        .PW (SPW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_c_vld),
        .i_rad   (r_c_len2),
        .i_pay   (w_sp_in),
        .o_valid (w_sp_vld),
        .o_root  (w_len),
        .o_pay   (w_sp_out)
    );

    assign w_dnum[0] = w_sp_out[PW+1  +: 32];
    assign w_dnum[1] = w_sp_out[PW+33 +: 32];
    assign w_dnum[2] = w_sp_out[PW+65 +: 32];

    ldq_div #(
        .NW (32),
        .DW (33),
        .QW (15),
        .PW (PW + 1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (w_sp_vld),
        .i_num   (w_dnum),
        .i_den   (w_len),
        .i_pay   (w_sp_out[PW:0]),
        .o_valid (o_valid),
        .o_quo   (w_quo),
        .o_pay   (w_dpay)
    );

    assign o_unit = w_quo;
    assign o_zero = w_dpay[PW];
    assign o_pay  = w_dpay[PW-1:0];

endmodule

// File: tb/look_direction_to_quaternion_top_test.sv
// self-checking testbench for the look direction to quaternion block
module look_direction_to_quaternion_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ldq_pkg::*;

    localparam int LATENCY = 159;
    localparam int N_RANDOM = 1130;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_DIRECTED = 14;

    typedef struct {
        logic signed [15:0] fx, fy, fz, ux, uy, uz;
    } t_pose;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic               degen;
    } t_quat;

    typedef struct {
        t_pose pose;
        logic  known;
        t_quat quat;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_fwd_x = '0, i_fwd_y = '0, i_fwd_z = '0;
    logic signed [15:0] i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic               o_degenerate;

    t_quat pending_quats[$];
    int    fail_count = 0;
    int    idle_cycles = 0;
    bit    stim_done = 1'b0;
    t_row  pose_table[N_DIRECTED];

    look_direction_to_quaternion_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned isqrt_round(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        if (n > res) res++;
        return res;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint scaled_quotient(longint num, longint unsigned den);
        longint unsigned m, q;
        if (den == 0) return 0;
        m = magnitude(num) << FRAC_BITS;
        q = (m + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit unit_vector(input longint v[3], output longint o[3]);
        longint unsigned m, len2, len;
        longint vs[3];
        int k;
        m = 0;
        len2 = 0;
        k = 0;
        for (int i = 0; i < 3; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
        while ((m >> k) >= (64'd1 << 31)) k++;
        for (int i = 0; i < 3; i++) begin
            vs[i] = v[i] / (longint'(1) << k);
            len2 += magnitude(vs[i]) * magnitude(vs[i]);
        end
        if (len2 == 0) return 1'b0;
        len = isqrt_round(len2);
        for (int i = 0; i < 3; i++) o[i] = scaled_quotient(vs[i], len);
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint unsigned half_root(longint rad);
        if (rad < 0) rad = 0;
        return isqrt_round(longint'(rad) << FRAC_BITS);
    endfunction

    function automatic t_quat orientation(t_pose p);
        longint one, f[3], up[3], c[3], r[3], ur[3], u[3];
        longint m00, m10, m20, m01, m11, m21, m02, m12, m22, tr, qw, qx, qy, qz;
        longint unsigned s, big;
        t_quat q;
        one = longint'(1) << FRAC_BITS;
        f = '{p.fx, p.fy, p.fz};
        up = '{p.ux, p.uy, p.uz};
        c[0] = f[1] * up[2] - f[2] * up[1];
        c[1] = f[2] * up[0] - f[0] * up[2];
        c[2] = f[0] * up[1] - f[1] * up[0];
        q = '{w: clamp16(one), x: 16'sd0, y: 16'sd0, z: 16'sd0, degen: 1'b1};
        if (!unit_vector(c, r)) return q;
        ur[0] = r[1] * f[2] - r[2] * f[1];
        ur[1] = r[2] * f[0] - r[0] * f[2];
        ur[2] = r[0] * f[1] - r[1] * f[0];
        if (!unit_vector(ur, u)) return q;
        m00 = r[0]; m10 = r[1]; m20 = r[2];
        m01 = u[0]; m11 = u[1]; m21 = u[2];
        m02 = -f[0]; m12 = -f[1]; m22 = -f[2];
        tr = m00 + m11 + m22;
        if (tr > 0) begin
            s = half_root(tr + one);
            big = 2 * s;
            qw = (s + 1) >> 1;
            qx = scaled_quotient(m21 - m12, big);
            qy = scaled_quotient(m02 - m20, big);
            qz = scaled_quotient(m10 - m01, big);
        end else if (m00 > m11 && m00 > m22) begin
            s = half_root(one + m00 - m11 - m22);
            big = 2 * s;
            qx = (s + 1) >> 1;
            qy = scaled_quotient(m01 + m10, big);
            qz = scaled_quotient(m02 + m20, big);
            qw = scaled_quotient(m21 - m12, big);
        end else if (m11 > m22) begin
            s = half_root(one + m11 - m00 - m22);
            big = 2 * s;
            qx = scaled_quotient(m01 + m10, big);
            qy = (s + 1) >> 1;
            qz = scaled_quotient(m12 + m21, big);
            qw = scaled_quotient(m02 - m20, big);
        end else begin
            s = half_root(one + m22 - m00 - m11);
            big = 2 * s;
            qx = scaled_quotient(m02 + m20, big);
            qy = scaled_quotient(m12 + m21, big);
            qz = (s + 1) >> 1;
            qw = scaled_quotient(m10 - m01, big);
        end
        q = '{w: clamp16(qw), x: clamp16(qx), y: clamp16(qy), z: clamp16(qz), degen: 1'b0};
        return q;
    endfunction

    function automatic logic signed [15:0] rand_unit_comp();
        int v;
        v = $urandom_range(32768, 0) - 16384;
        return 16'(v);
    endfunction

    function automatic t_pose random_pose();
        t_pose p;
        int mode;
        mode = $urandom_range(9);
        p.fx = rand_unit_comp();
        p.fy = rand_unit_comp();
        p.fz = rand_unit_comp();
        p.ux = rand_unit_comp();
        p.uy = rand_unit_comp();
        p.uz = rand_unit_comp();
        if (mode == 0) begin
            p = '{16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom)};
        end else if (mode == 1) begin
            p.ux = p.fx;
            p.uy = p.fy;
            p.uz = p.fz;
        end else if (mode == 2) begin
            p.ux = -p.fx;
            p.uy = -p.fy;
            p.uz = -p.fz;
        end
        return p;
    endfunction

    task automatic gap_before_beat();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(2);
        if ($urandom_range(3) == 0) n = 0;
        repeat (n) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_pose(t_pose p);
        i_valid <= 1'b1;
        {i_fwd_x, i_fwd_y, i_fwd_z} <= {p.fx, p.fy, p.fz};
        {i_up_x, i_up_y, i_up_z} <= {p.ux, p.uy, p.uz};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic push_quat(t_quat q);
        pending_quats.push_back(q);
    endtask

    task automatic check_field(string name, logic signed [15:0] exp_v,
                               logic signed [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_quat q;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_quats.size() == 0) begin
                $error("result beat with no expected quaternion");
                fail_count++;
            end else begin
                q = pending_quats.pop_front();
                check_field("quat_w", q.w, o_quat_w);
                check_field("quat_x", q.x, o_quat_x);
                check_field("quat_y", q.y, o_quat_y);
                check_field("quat_z", q.z, o_quat_z);
                check_field("degenerate", 16'(q.degen), 16'(o_degenerate));
            end
        end
    end

    always @(posedge i_clk) begin
        int n;
        if ($urandom_range(19) == 0) n = $urandom_range(30, 5);
        else n = $urandom_range(3) == 0 ? 1 : 0;
        if (n != 0) begin
            i_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
        end
        i_stall <= 1'b0;
        if ($urandom_range(3) == 0) repeat ($urandom_range(60, 10)) @(posedge i_clk);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_quat ident;
        t_pose p;
        ident = '{w: ONE_Q, x: 16'sd0, y: 16'sd0, z: 16'sd0, degen: 1'b1};
        // identity pose, parallel and antiparallel, zero, extremes, axis-aligned, tiny, random-looking and non-unit
        pose_table[0] = '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, ident};
        pose_table[1] = '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b1, ident};
        pose_table[2] = '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b1, ident};
        pose_table[3] = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, ident};
        pose_table[4] = '{'{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b1, ident};
        pose_table[5] = '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff},
                          1'b0, ident};
        pose_table[6] = '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000},
                          1'b0, ident};
        pose_table[7] = '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, ident};
        pose_table[8] = '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, ident};
        pose_table[9] = '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, ident};
        pose_table[10] = '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, ident};
        pose_table[11] = '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1'b0, ident};
        pose_table[12] = '{'{16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 16'sh0f0f, 16'shf0f0},
                           1'b0, ident};
        pose_table[13] = '{'{16'sd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 1'b0, ident};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (pose_table[i]) begin
            gap_before_beat();
            push_quat(pose_table[i].known ? pose_table[i].quat : orientation(pose_table[i].pose));
            send_pose(pose_table[i].pose);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (pending_quats.size() != 0) @(posedge i_clk);
            end
            gap_before_beat();
            p = random_pose();
            push_quat(orientation(p));
            send_pose(p);
        end
        i_valid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: look_direction_to_quaternion_top.f
+incdir+rtl
rtl/ldq_pkg.sv
rtl/ldq_sqrt.sv
rtl/ldq_div.sv
rtl/ldq_norm.sv
rtl/look_direction_to_quaternion_top.sv
tb/look_direction_to_quaternion_top_test.sv
